// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of the chunk filter.
// No dependencies; each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define PCMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define PCMF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/pcmf_pkg.sv =====
// Shared types, constants and a helper function for the chunk metadata filter.
// No dependencies.
package pcmf_pkg;

	// byte counter width; the bound check works at any value from 16 to 64
	localparam int POSITION_BITS = 32;
	localparam int SUM_BITS      = ((POSITION_BITS > 33) ? POSITION_BITS : 33) + 1;
	localparam int SIG_BYTES     = 8;

	// command queue between parser and record writer
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PASS_SBIT     = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STREAM_LENGTH = 1'd1;

	// chunk type tags, big-endian ASCII
	localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
	localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
	localparam logic [31:0] TAG_IEND = 32'h4945_4E44;
	localparam logic [31:0] TAG_PLTE = 32'h504C_5445;
	localparam logic [31:0] TAG_TRNS = 32'h7452_4E53;
	localparam logic [31:0] TAG_BKGD = 32'h624B_4744;
	localparam logic [31:0] TAG_HIST = 32'h6849_5354;
	localparam logic [31:0] TAG_ACTL = 32'h6163_544C;
	localparam logic [31:0] TAG_FCTL = 32'h6663_544C;
	localparam logic [31:0] TAG_FDAT = 32'h6664_4154;
	localparam logic [31:0] TAG_SBIT = 32'h7342_4954;

	// one queued job: a record header (type + length) or a single data byte
	typedef struct packed {
		logic        is_hdr;
		logic [31:0] ctype;
		logic [31:0] clen;   // data byte sits in clen[7:0]
	} cmd_t;

	// structural and pixel-layout chunks are not passed on; sBIT only with pass_sbit
	function automatic logic type_dropped(input logic [31:0] t, input logic pass_sbit);
		logic hit;
		hit = (t == TAG_IHDR) || (t == TAG_IDAT) || (t == TAG_IEND) ||
		      (t == TAG_PLTE) || (t == TAG_TRNS) || (t == TAG_BKGD) ||
		      (t == TAG_HIST) || (t == TAG_ACTL) || (t == TAG_FCTL) ||
		      (t == TAG_FDAT);
		return hit || (!pass_sbit && (t == TAG_SBIT));
	endfunction

endpackage

// ===== design/pcmf_cmd_fifo.sv =====
// Small command queue between the parser and the record writer.
// Depends on pcmf_pkg (cmd_t, FIFO_DEPTH).
module pcmf_cmd_fifo import pcmf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

endmodule

// ===== design/pcmf_front.sv =====
// Stream parser: walks signature, headers, data and CRC one byte per beat
// and queues record commands. Holds the configuration registers.
// Depends on pcmf_pkg.
module pcmf_front import pcmf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  logic [7:0]                data_byte,
	input  logic                      start_of_stream,
	output logic                      full,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [31:0]               wr_data,
	output logic                      cmd_push,
	output cmd_t                      cmd,
	input  logic                      cmd_full
);

	typedef enum logic [2:0] {PH_SIG, PH_HDR, PH_DATA, PH_CRC, PH_STOP} phase_t;

	phase_t                   phase_q, phase_d, phase_e;
	logic [POSITION_BITS-1:0] pos_q, pos_d, pos_e, pos_n;
	logic [31:0]              left_q, left_d, left_e;
	logic [31:0]              len_q, len_d;
	logic [31:0]              type_q, type_d;
	logic                     keep_q, keep_d, keep_e;
	logic [32:0]              len4_q;
	logic                     pass_sbit_q;
	logic [31:0]              stream_len_q;
	logic                     acc;
	logic                     sat;
	logic                     push_c;
	logic [SUM_BITS-1:0]      end_sum;
	logic                     overrun;

	assign full = cmd_full;
	assign acc  = push && !cmd_full;

	// a start mark restarts the walk on this very byte
	assign phase_e = start_of_stream ? PH_SIG : phase_q;
	assign pos_e   = start_of_stream ? '0 : pos_q;
	assign left_e  = start_of_stream ? '0 : left_q;
	assign keep_e  = start_of_stream ? 1'b0 : keep_q;

	// saturating byte count
	assign sat   = &pos_e;
	assign pos_n = sat ? pos_e : pos_e + POSITION_BITS'(1);

	// end of data plus CRC, measured from the updated position
	assign end_sum = SUM_BITS'(pos_e) + SUM_BITS'(len4_q) + SUM_BITS'(!sat);
	assign overrun = (SUM_BITS'(pos_n) > SUM_BITS'(stream_len_q)) ||
	                 (end_sum > SUM_BITS'(stream_len_q));

	// next state and command for one accepted byte
	always_comb begin
		phase_d = phase_e;
		left_d  = left_e;
		len_d   = len_q;
		type_d  = type_q;
		keep_d  = keep_e;
		pos_d   = (phase_e == PH_STOP) ? pos_e : pos_n;
		push_c  = 1'b0;
		cmd     = '{is_hdr: 1'b0, ctype: type_q, clen: {24'd0, data_byte}};
		unique case (phase_e)
			PH_SIG: begin
				if (pos_e >= POSITION_BITS'(SIG_BYTES - 1)) begin
					phase_d = PH_HDR;
					left_d  = 32'd8;
				end
			end
			PH_HDR: begin
				if (left_e > 32'd4) begin
					len_d = {len_q[23:0], data_byte};
				end else begin
					type_d = {type_q[23:0], data_byte};
				end
				left_d = left_e - 32'd1;
				if (left_e == 32'd1) begin
					if (overrun || (type_d == TAG_IEND)) begin
						phase_d = PH_STOP;
					end else begin
						keep_d = !type_dropped(type_d, pass_sbit_q);
						push_c = keep_d;
						cmd    = '{is_hdr: 1'b1, ctype: type_d, clen: len_q};
						if (len_q != 32'd0) begin
							phase_d = PH_DATA;
							left_d  = len_q;
						end else begin
							phase_d = PH_CRC;
							left_d  = 32'd4;
						end
					end
				end
			end
			PH_DATA: begin
				push_c = keep_e;
				left_d = left_e - 32'd1;
				if (left_e == 32'd1) begin
					phase_d = PH_CRC;
					left_d  = 32'd4;
				end
			end
			PH_CRC: begin
				left_d = left_e - 32'd1;
				if (left_e == 32'd1) begin
					phase_d = PH_HDR;
					left_d  = 32'd8;
				end
			end
			PH_STOP: begin
				phase_d = PH_STOP;
			end
			default: begin
				phase_d = PH_STOP;
			end
		endcase
	end

	assign cmd_push = acc && push_c;

	// parser state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIG;
			pos_q        <= '0;
			left_q       <= '0;
			len_q        <= '0;
			type_q       <= '0;
			keep_q       <= 1'b0;
			len4_q       <= '0;
			pass_sbit_q  <= 1'b0;
			stream_len_q <= '0;
		end else begin
			// length is complete several beats before it is checked
			len4_q <= {1'b0, len_q} + 33'd4;
			if (acc) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				left_q  <= left_d;
				len_q   <= len_d;
				type_q  <= type_d;
				keep_q  <= keep_d;
			end
			if (wr_en) begin
				unique case (wr_index)
					CFG_PASS_SBIT:     pass_sbit_q  <= wr_data[0];
					CFG_STREAM_LENGTH: stream_len_q <= wr_data;
					default:           stream_len_q <= stream_len_q;
				endcase
			end
		end
	end

endmodule

// ===== design/pcmf_back.sv =====
// Record writer: expands queued commands into output bytes, one per beat,
// through a single output register.
// Depends on pcmf_pkg (cmd_t).
module pcmf_back import pcmf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       head_empty,
	output logic       head_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       end_of_run
);

	cmd_t       cur_q;
	logic [2:0] idx_q;
	logic       busy_q;
	logic       ovalid_q;
	logic [7:0] obyte_q;
	logic       oend_q;
	logic       out_free;
	logic       advance;
	logic       cur_last;
	logic [7:0] sel_byte;

	assign out_free = !ovalid_q || pop;
	assign advance  = busy_q && out_free;
	assign cur_last = !cur_q.is_hdr || (idx_q == 3'd7);
	assign head_pop = !head_empty && (!busy_q || (advance && cur_last));

	// type bytes in stream order, then length little-endian
	always_comb begin
		if (!cur_q.is_hdr) begin
			sel_byte = cur_q.clen[7:0];
		end else if (!idx_q[2]) begin
			sel_byte = cur_q.ctype[8*(3 - idx_q[1:0]) +: 8];
		end else begin
			sel_byte = cur_q.clen[8*idx_q[1:0] +: 8];
		end
	end

	assign empty      = !ovalid_q;
	assign out_byte   = obyte_q;
	assign end_of_run = oend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			cur_q    <= '0;
			ovalid_q <= 1'b0;
			obyte_q  <= '0;
			oend_q   <= 1'b0;
		end else begin
			// output register
			if (out_free) begin
				ovalid_q <= busy_q;
				if (busy_q) begin
					obyte_q <= sel_byte;
					oend_q  <= cur_last;
				end
			end
			// take the next command, else step through the current one
			if (head_pop) begin
				cur_q  <= head;
				idx_q  <= '0;
				busy_q <= 1'b1;
			end else if (advance) begin
				idx_q <= idx_q + 3'd1;
				if (cur_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== design/png_chunk_metadata_filter_unit.sv =====
// Input takes one stream byte per cycle and stalls (full) only when the
// four-entry command queue between parser and record writer is full. Each
// kept chunk header queues one command that the writer turns into 8 output
// beats; each kept data byte gives one beat. Output runs at one beat per
// cycle while pop is held and commands are queued, set by the writer's
// single output register. Registers are written through wr_en / wr_index /
// wr_data and should change only while idle.
// Top level; depends on pcmf_pkg, pcmf_front, pcmf_cmd_fifo, pcmf_back.
module png_chunk_metadata_filter_unit import pcmf_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [7:0]                data_byte,
	input  logic                      start_of_stream,
	output logic                      empty,
	input  logic                      pop,
	output logic [7:0]                out_byte,
	output logic                      end_of_run,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [31:0]               wr_data
);

	cmd_t q_wr_cmd;
	cmd_t q_rd_cmd;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	// parser
	pcmf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.data_byte       (data_byte),
		.start_of_stream (start_of_stream),
		.full            (full),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.cmd_push        (q_push),
		.cmd             (q_wr_cmd),
		.cmd_full        (q_full)
	);

	// command queue
	pcmf_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	// record writer
	pcmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rd_cmd),
		.head_empty (q_empty),
		.head_pop   (q_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.end_of_run (end_of_run)
	);

endmodule

// ===== design/pcmf_checker.sv =====
// Port-level checks for the chunk filter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pcmf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       end_of_run
);

	// a waiting result holds until taken
	`PCMF_ASSERT_NOW(a_out_hold, $past(!empty && !pop), !empty && $stable(out_byte) && $stable(end_of_run), "result changed while stalled")

	// header bytes of a record come out without gaps
	`PCMF_ASSERT_NEXT(a_run_contiguous, pop && !empty && !end_of_run, !empty, "gap inside a record header")

	// with no input beat the queue cannot fill up
	`PCMF_ASSERT_NEXT(a_full_needs_push, !push && !full, !full, "full rose without an input beat")

endmodule

bind png_chunk_metadata_filter_unit pcmf_checker u_pcmf_checker (.*);
